// ===== sv/cc608_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc608_pkg
// Shared types and constants for the 608 caption channel demux.
// ----------------------------------------------------------------------------
package cc608_pkg;

  // configuration register indexes
  localparam logic CFG_CHANNEL_SELECT = 1'b0;
  localparam logic CFG_FIELD_SELECT   = 1'b1;

  localparam int unsigned CFG_DATA_W = 4;

  // caption modes
  localparam logic [3:0] MODE_NONE  = 4'd0;
  localparam logic [3:0] MODE_CC1   = 4'd1;
  localparam logic [3:0] MODE_CC2   = 4'd2;
  localparam logic [3:0] MODE_TEXT1 = 4'd5;
  localparam logic [3:0] MODE_TEXT2 = 4'd6;
  localparam logic [3:0] MODE_XDS   = 4'd9;

  // channel select value that disables mode filtering
  localparam logic [3:0] CHAN_XDS = 4'd8;

  // header codes
  localparam logic [7:0] HDR_JUNK_LIMIT = 8'hF8;
  localparam logic [7:0] HDR_DTV_LIMIT  = 8'hFE;
  localparam logic [6:0] HDR_608_TAG    = 7'b1111110;

  // word masks and control codes
  localparam logic [15:0] PARITY_MASK  = 16'h7F7F;
  localparam logic [15:0] TEXT_MASK    = 16'h6000;
  localparam logic [15:0] XDS_HI_MASK  = 16'h7070;
  localparam logic [15:0] XDS_LO_MASK  = 16'h0F0F;
  localparam logic [15:0] XDS_END_MASK = 16'h7F00;
  localparam logic [15:0] XDS_END_CODE = 16'h0F00;
  localparam logic [15:0] CHAN_BIT     = 16'h0800;
  localparam logic [15:0] CODE_RCL     = 16'h1420;
  localparam logic [15:0] CODE_RU_LO   = 16'h1425;
  localparam logic [15:0] CODE_RU_HI   = 16'h1427;
  localparam logic [15:0] CODE_RDC     = 16'h1429;
  localparam logic [15:0] CODE_RTD     = 16'h142B;

  typedef struct packed {
    logic [7:0] cc_header;
    logic [7:0] cc_byte_one;
    logic [7:0] cc_byte_two;
  } in_item_t;

  typedef struct packed {
    logic [1:0] char_count;
    logic [6:0] first_char;
    logic [6:0] second_char;
    logic       end_line;
    logic [3:0] current_mode;
    logic       junk_flag;
    logic       dtv_flag;
  } out_item_t;

  typedef struct packed {
    logic [3:0] caption_mode;
    logic [3:0] xds_return_mode;
    logic       line_has_text;
  } dmx_state_t;

endpackage

// ===== sv/cc608_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc608_decode
// Combinational decode of one caption packet against the current mode state.
// ----------------------------------------------------------------------------
module cc608_decode (
  input  cc608_pkg::in_item_t   item_i,
  input  cc608_pkg::dmx_state_t state_i,
  input  logic [3:0]            channel_select_i,
  input  logic                  field_select_i,
  output cc608_pkg::out_item_t  result_o,
  output cc608_pkg::dmx_state_t state_o
);
  import cc608_pkg::*;

  logic [15:0] word;
  logic [15:0] code;
  logic        is_608;
  logic        ctrl;
  logic        even;
  logic        pass;
  logic [3:0]  mode_d;
  logic [3:0]  ret_d;
  logic [3:0]  pac_mode;
  logic [4:0]  sel_mode;

  assign word = {item_i.cc_byte_one, item_i.cc_byte_two} & PARITY_MASK;
  assign code = word & ~CHAN_BIT;
  assign even = item_i.cc_header[0];
  assign ctrl = (word & TEXT_MASK) == 16'h0000;

  assign is_608 = (item_i.cc_header[7:1] == HDR_608_TAG) &&
                  (item_i.cc_header[0] == field_select_i) && (word != 16'h0000);

  assign pac_mode = {3'b000, word[11]} + (even ? 4'd2 : 4'd0);

  // mode tracking
  always_comb begin
    mode_d = state_i.caption_mode;
    ret_d  = state_i.xds_return_mode;
    if (ctrl) begin
      if (state_i.caption_mode == MODE_XDS && (word & XDS_END_MASK) == XDS_END_CODE) begin
        mode_d = state_i.xds_return_mode;
      end else if ((word & XDS_HI_MASK) == 16'h0000 && (word & XDS_LO_MASK) != 16'h0000) begin
        if (state_i.caption_mode != MODE_XDS) begin
          ret_d  = state_i.caption_mode;
          mode_d = MODE_XDS;
        end
      end else if (state_i.caption_mode != MODE_XDS) begin
        if (code == CODE_RCL || code == CODE_RDC ||
            (code >= CODE_RU_LO && code <= CODE_RU_HI)) begin
          mode_d = MODE_CC1 + pac_mode;
        end else if (code == CODE_RTD) begin
          mode_d = MODE_TEXT1 + pac_mode;
        end
      end
    end
  end

  assign sel_mode = {1'b0, channel_select_i} + 5'd1;
  assign pass = (channel_select_i >= CHAN_XDS) || ({1'b0, mode_d} == sel_mode);

  always_comb begin
    result_o = '0;
    state_o  = state_i;
    result_o.junk_flag = item_i.cc_header < HDR_JUNK_LIMIT;
    result_o.dtv_flag  = item_i.cc_header >= HDR_DTV_LIMIT;
    if (is_608) begin
      state_o.caption_mode    = mode_d;
      state_o.xds_return_mode = ret_d;
      if (pass) begin
        if (!ctrl) begin
          result_o.first_char = word[14:8];
          result_o.char_count = 2'd1;
          if (word[7:0] != 8'h00) begin
            result_o.second_char = word[6:0];
            result_o.char_count  = 2'd2;
          end
          state_o.line_has_text = 1'b1;
        end else if (state_i.line_has_text) begin
          state_o.line_has_text = 1'b0;
          result_o.end_line     = 1'b1;
        end
      end
    end
    result_o.current_mode = state_o.caption_mode;
  end

endmodule

// ===== sv/caption_608_channel_demux.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caption_608_channel_demux
// Splits one 608 caption channel out of a stream of three-byte packets.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_stall_o / in_item_i, one packet per item
//   out channel : out_valid_o / out_stall_i / out_item_o, one result per item
//   cfg port    : cfg_we_i, cfg_index_i, cfg_wdata_i; write only while idle
// The packet lands in an input register, and the decode runs between that
// register and the result register. Throughput is one item per cycle while
// the output is not stalled, set by the single decode pass and the mode
// state update that it feeds back with each item.
// A stalled result holds in the output register; the input register keeps
// its item until the output register frees up, and the input side stalls
// only while the input register is full and the output cannot take it.
// Reset clears both valid flags, the mode state and the configuration
// registers; the block can accept an item as soon as reset is released.
// ----------------------------------------------------------------------------
module caption_608_channel_demux (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cc608_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cc608_pkg::out_item_t out_item_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [cc608_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import cc608_pkg::*;

  logic [3:0] channel_select_q;
  logic       field_select_q;

  in_item_t   in_q;
  logic       in_valid_q;
  out_item_t  out_q;
  out_item_t  out_d;
  logic       out_valid_q;
  dmx_state_t state_q;
  dmx_state_t state_d;

  logic out_ready;
  logic advance;
  logic in_take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_select_q <= '0;
      field_select_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CHANNEL_SELECT: channel_select_q <= cfg_wdata_i;
        CFG_FIELD_SELECT:   field_select_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  cc608_decode u_decode (
    .item_i           (in_q),
    .state_i          (state_q),
    .channel_select_i (channel_select_q),
    .field_select_i   (field_select_q),
    .result_o         (out_d),
    .state_o          (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== sv/cc608_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc608_checker
// Port-level checks for the 608 caption channel demux.
// ----------------------------------------------------------------------------
module cc608_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input cc608_pkg::out_item_t out_item_o
);
  import cc608_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // characters and end of line come only from a 608 packet, and never together
  a_text_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.char_count != 2'd0 || out_item_o.end_line) |->
      !out_item_o.junk_flag && !out_item_o.dtv_flag && !(out_item_o.end_line &&
      out_item_o.char_count != 2'd0))
    else $error("text or end of line on a non-608 item");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.char_count != 2'd3 &&
      (out_item_o.char_count == 2'd2 || out_item_o.second_char == 7'd0) &&
      (out_item_o.char_count != 2'd0 || out_item_o.first_char == 7'd0))
    else $error("character fields disagree with count");

  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.current_mode <= MODE_XDS)
    else $error("mode out of range");

endmodule

bind caption_608_channel_demux cc608_checker u_cc608_checker (.*);
